@@ design/jfss_pkg.sv @@
// ----------------------------------------------------------------------------
// jfss_pkg
// Shared types and codes for the JPEG frame size scanner: result status codes
// and the result word that travels from the parser to the output register.
// ----------------------------------------------------------------------------
package jfss_pkg;

    localparam int unsigned STATUS_W = 3;
    localparam int unsigned DIM_W    = 16;
    localparam int unsigned SIZE_W   = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADSTART = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_ENDHIT   = 3'd3,
        ST_BADLEN   = 3'd4,
        ST_SHORTSOF = 3'd5,
        ST_ZEROSIZE = 3'd6
    } jfss_status_t;

    typedef struct packed {
        jfss_status_t     status;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } jfss_result_t;

endpackage

@@ design/jfss_parse.sv @@
// ----------------------------------------------------------------------------
// jfss_parse
// Marker parser: holds the parse phase, byte position, segment length and
// dimension accumulators, and decides on each byte whether a result is due.
// ----------------------------------------------------------------------------
module jfss_parse (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [7:0]                         data_byte,
    input  logic                               first_byte,
    input  logic [jfss_pkg::SIZE_W-1:0]        total_size,
    output logic                               emit,
    output jfss_pkg::jfss_result_t             result
);

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_SOI2  = 8'b0000_0010,
        PH_SEEK  = 8'b0000_0100,
        PH_FILL  = 8'b0000_1000,
        PH_LENHI = 8'b0001_0000,
        PH_LENLO = 8'b0010_0000,
        PH_SKIP  = 8'b0100_0000,
        PH_FRAME = 8'b1000_0000
    } jfss_phase_t;

    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_SOF0 = 8'hC0;

    function automatic logic is_standalone(input logic [7:0] m);
        return (m == MK_SOI) || (m == MK_TEM) || (m >= MK_RST0 && m <= MK_RST7);
    endfunction

    // SOF0..SOF15 except DHT (C4), JPG (C8) and DAC (CC)
    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m[7:4] == MK_SOF0[7:4]) && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
    endfunction

    jfss_phase_t                  phase_reg, phase_next;
    logic [jfss_pkg::SIZE_W-1:0]  pos_reg, pos_next;
    logic [7:0]                   len_hi_reg, len_hi_next;
    logic [15:0]                  skip_reg, skip_next;
    logic                         frame_reg, frame_next;
    logic [jfss_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [jfss_pkg::DIM_W-1:0]   height_reg, height_next;
    logic                         decided_reg, decided_next;

    logic [32:0]                  pos_p1;
    logic [33:0]                  pos_p2;
    logic                         near_end1;
    logic                         near_end2;
    logic [15:0]                  len_val;
    logic                         len_past_end;
    jfss_pkg::jfss_status_t       emit_status;

    // Position checks in wider arithmetic so a wrap of the position is harmless
    assign pos_p1       = {1'b0, pos_reg} + 33'd1;
    assign pos_p2       = {2'b0, pos_reg} + 34'd2;
    assign near_end1    = pos_p1 >= {1'b0, total_size};
    assign near_end2    = pos_p2 >= {2'b0, total_size};
    assign len_val      = {len_hi_reg, data_byte};
    assign len_past_end = ({17'b0, len_val} + {1'b0, pos_reg}) > ({1'b0, total_size} + 33'd1);

    // Next state and result decision for the byte at the input
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_hi_next  = len_hi_reg;
        skip_next    = skip_reg;
        frame_next   = frame_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        emit_status  = jfss_pkg::ST_OK;

        if (first_byte)
        begin
            decided_next = 1'b0;
            len_hi_next  = 8'd0;
            skip_next    = 16'd0;
            frame_next   = 1'b0;
            width_next   = '0;
            height_next  = '0;
            pos_next     = 32'd1;
            if (total_size < 32'd4 || data_byte != MK_FILL)
            begin
                emit        = 1'b1;
                emit_status = jfss_pkg::ST_BADSTART;
            end
            else
            begin
                phase_next = PH_SOI2;
            end
        end
        else if (!decided_reg)
        begin
            pos_next = pos_reg + 32'd1;
            unique case (phase_reg)
                PH_SOI2:
                begin
                    if (data_byte != MK_SOI)
                    begin
                        emit        = 1'b1;
                        emit_status = jfss_pkg::ST_BADSTART;
                    end
                    else if (near_end2)
                    begin
                        emit        = 1'b1;
                        emit_status = jfss_pkg::ST_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_SEEK;
                    end
                end
                PH_SEEK:
                begin
                    if (data_byte == MK_FILL)
                        phase_next = PH_FILL;
                    if (near_end1)
                    begin
                        emit        = 1'b1;
                        emit_status = jfss_pkg::ST_TRUNC;
                    end
                end
                PH_FILL:
                begin
                    if (data_byte == MK_FILL)
                    begin
                        if (near_end1)
                        begin
                            emit        = 1'b1;
                            emit_status = jfss_pkg::ST_TRUNC;
                        end
                    end
                    else
                    begin
                        frame_next = is_frame_marker(data_byte);
                        if (is_standalone(data_byte))
                        begin
                            if (near_end2)
                            begin
                                emit        = 1'b1;
                                emit_status = jfss_pkg::ST_TRUNC;
                            end
                            else
                            begin
                                phase_next = PH_SEEK;
                            end
                        end
                        else if (data_byte == MK_EOI || data_byte == MK_SOS)
                        begin
                            emit        = 1'b1;
                            emit_status = jfss_pkg::ST_ENDHIT;
                        end
                        else if (near_end2)
                        begin
                            emit        = 1'b1;
                            emit_status = jfss_pkg::ST_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_LENHI;
                        end
                    end
                end
                PH_LENHI:
                begin
                    len_hi_next = data_byte;
                    phase_next  = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (len_val < 16'd2 || len_past_end)
                    begin
                        emit        = 1'b1;
                        emit_status = jfss_pkg::ST_BADLEN;
                    end
                    else if (frame_reg)
                    begin
                        if (len_val < 16'd7)
                        begin
                            emit        = 1'b1;
                            emit_status = jfss_pkg::ST_SHORTSOF;
                        end
                        else
                        begin
                            skip_next  = 16'd5;
                            phase_next = PH_FRAME;
                        end
                    end
                    else
                    begin
                        skip_next = len_val - 16'd2;
                        if (len_val == 16'd2)
                        begin
                            if (near_end2)
                            begin
                                emit        = 1'b1;
                                emit_status = jfss_pkg::ST_TRUNC;
                            end
                            else
                            begin
                                phase_next = PH_SEEK;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (skip_reg <= 16'd1)
                    begin
                        skip_next = 16'd0;
                        if (near_end2)
                        begin
                            emit        = 1'b1;
                            emit_status = jfss_pkg::ST_TRUNC;
                        end
                        else
                        begin
                            phase_next = PH_SEEK;
                        end
                    end
                    else
                    begin
                        skip_next = skip_reg - 16'd1;
                    end
                end
                PH_FRAME:
                begin
                    // precision, height hi/lo, width hi/lo
                    if (skip_reg == 16'd4 || skip_reg == 16'd3)
                        height_next = {height_reg[7:0], data_byte};
                    else if (skip_reg <= 16'd2)
                        width_next = {width_reg[7:0], data_byte};
                    if (skip_reg <= 16'd1)
                    begin
                        skip_next   = 16'd0;
                        emit        = 1'b1;
                        if (width_next == '0 || height_next == '0)
                            emit_status = jfss_pkg::ST_ZEROSIZE;
                        else
                            emit_status = jfss_pkg::ST_OK;
                    end
                    else
                    begin
                        skip_next = skip_reg - 16'd1;
                    end
                end
                default:
                begin
                    decided_next = 1'b1;
                    phase_next   = PH_IDLE;
                end
            endcase
        end

        // A result closes the scan
        if (emit)
        begin
            decided_next = 1'b1;
            phase_next   = PH_IDLE;
        end
    end

    // Drive the result word; dimensions only with an ok status
    always_comb
    begin
        result.status = emit_status;
        result.width  = (emit_status == jfss_pkg::ST_OK) ? width_next  : '0;
        result.height = (emit_status == jfss_pkg::ST_OK) ? height_next : '0;
    end

    // Advance the parse state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            len_hi_reg  <= '0;
            skip_reg    <= '0;
            frame_reg   <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            decided_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_hi_reg  <= len_hi_next;
            skip_reg    <= skip_next;
            frame_reg   <= frame_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            decided_reg <= decided_next;
        end
    end

endmodule

@@ design/jfss_out_stage.sv @@
// ----------------------------------------------------------------------------
// jfss_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module jfss_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  jfss_pkg::jfss_result_t result_in,
    input  logic                   out_ready,
    output logic                   out_valid,
    output jfss_pkg::jfss_result_t result_out
);

    logic                   valid_reg, valid_next;
    jfss_pkg::jfss_result_t data_reg;

    // Hold until taken, refill on load
    assign valid_next = load | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

@@ design/jpeg_frame_size_scanner_core.sv @@
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_core
// Byte-serial JPEG scanner reporting the frame width and height.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the file one byte per word on the input channel (in_valid/in_ready),
//   with first_byte high on byte 0; that restarts the scan. Write the file
//   length to total_size through cfg_wr_en/cfg_wr_data while the block is idle.
//   At most one result word per file leaves on the output channel
//   (out_valid/out_ready): status plus image_width and image_height, the
//   dimensions being zero unless status is ok. Bytes after the result are
//   dropped until the next first_byte.
//   A taken byte sits in the input register, is parsed combinationally and
//   its result is loaded into the result register once that register can
//   take it.
//   Throughput: one byte per cycle unless a byte with a result waits on a
//   stalled receiver; the parse step between the input register and the result register is combinational.
//   Reset clears the scan state to "nothing to scan" and total_size to zero;
//   bytes without first_byte then give no result.
//   When the receiver stalls with a result pending, bytes that produce no
//   result still flow; a byte that produces one waits in the input register.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [jfss_pkg::SIZE_W-1:0]       cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              first_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [jfss_pkg::STATUS_W-1:0]     status,
    output logic [jfss_pkg::DIM_W-1:0]        image_width,
    output logic [jfss_pkg::DIM_W-1:0]        image_height
);

    logic [jfss_pkg::SIZE_W-1:0] total_size_reg;
    logic                        in_valid_reg;
    logic [7:0]                  byte_reg;
    logic                        first_reg;
    logic                        advance;
    logic                        emit;
    jfss_pkg::jfss_result_t      result;
    jfss_pkg::jfss_result_t      result_q;

    // Hold the file size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_size_reg <= '0;
        else if (cfg_wr_en)
            total_size_reg <= cfg_wr_data;
    end

    // Advance when the byte gives no result or the result register is free
    assign advance  = in_valid_reg & (~emit | ~out_valid | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
        end
    end

    jfss_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (byte_reg),
        .first_byte (first_reg),
        .total_size (total_size_reg),
        .emit       (emit),
        .result     (result)
    );

    jfss_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance & emit),
        .result_in  (result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_out (result_q)
    );

    assign status       = result_q.status;
    assign image_width  = result_q.width;
    assign image_height = result_q.height;

    // A failed scan never reports dimensions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != jfss_pkg::ST_OK |-> image_width == '0 && image_height == '0)
        else $error("dimensions reported with an error status");

    // An ok result always carries nonzero dimensions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == jfss_pkg::ST_OK |-> image_width != '0 && image_height != '0)
        else $error("ok status with a zero dimension");

    // Input stalls only behind a pending result that is not being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && emit && out_valid && !out_ready)
        else $error("input stalled without a blocked result");

endmodule
